// File: rtl/sha256_message_hasher_top_macros.svh
// Assertion macros shared by the hasher RTL.
`ifndef SHA256_MESSAGE_HASHER_TOP_MACROS_SVH
`define SHA256_MESSAGE_HASHER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the block clock and disabled during reset.
`define SHAMH_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the block clock and disabled during reset.
`define SHAMH_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/shamh_pkg.sv
// Shared types, constants and helper functions of the SHA-256 message hasher.
package shamh_pkg;

   localparam int unsigned ROUNDS = 64;
   localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);
   localparam logic [5:0] LAST_BYTE_POS = 6'd63;
   localparam logic [5:0] LEN_FIELD_POS = 6'd56;
   localparam logic [2:0] LAST_WORD_INDEX = 3'd7;
   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_PAD_LEN,
      ST_OUT
   } state_type;

   // Commands to the block buffer and message schedule.
   typedef struct packed {
      logic       write_byte;
      logic       pad_mark;
      logic       pad_clear;
      logic       pad_len;
      logic       shift;
      logic [5:0] byte_pos;
      logic [7:0] byte_data;
   } sched_ctrl_type;

   // Commands to the round unit and chaining value.
   typedef struct packed {
      logic       load;
      logic       step;
      logic       add;
      logic       out_shift;
      logic [5:0] round;
      logic [2:0] out_index;
   } round_ctrl_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// File: rtl/shamh_stream_if.sv
// Valid/ready channel interfaces for message bytes and digest words.
interface shamh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last;

   modport source (output valid, output data_byte, output byte_valid, output last,
                   input ready);
   modport sink (input valid, input data_byte, input byte_valid, input last,
                 output ready);
endinterface

interface shamh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink (input valid, input digest_word, input word_index, input last_word,
                 output ready);
endinterface

// File: rtl/shamh_schedule.sv
// Block buffer that doubles as the sliding message schedule window.
module shamh_schedule (
   input  logic                     clock,
   input  shamh_pkg::sched_ctrl_type ctrl,
   input  logic [63:0]              msg_bits,
   output logic [31:0]              w_word
);
   import shamh_pkg::*;

   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [31:0] next_word;
   logic [3:0]  word_sel;
   logic [1:0]  lane_sel;
   logic [4:0]  lane_base;

   assign word_sel  = ctrl.byte_pos[5:2];
   assign lane_sel  = ctrl.byte_pos[1:0];
   // Lane zero is the most significant byte, as the words are big-endian.
   assign lane_base = {~lane_sel, 3'b000};
   assign next_word = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];
   assign w_word    = win_ff[0];

   always_comb begin
      win_in = win_ff;
      if (ctrl.shift) begin
         for (int j = 0; j < 15; j++) begin
            win_in[j] = win_ff[j + 1];
         end
         win_in[15] = next_word;
      end else if (ctrl.write_byte) begin
         win_in[word_sel][lane_base +: 8] = ctrl.byte_data;
      end else if (ctrl.pad_mark || ctrl.pad_clear) begin
         // Words past the mark are cleared; the marked word keeps its leading bytes.
         for (int j = 0; j < 16; j++) begin
            if (ctrl.pad_clear || (4'(j) > word_sel)) begin
               win_in[j] = '0;
            end else if (4'(j) == word_sel) begin
               for (int l = 0; l < 4; l++) begin
                  if (2'(l) == lane_sel) begin
                     win_in[j][(3 - l) * 8 +: 8] = PAD_MARK_BYTE;
                  end else if (2'(l) > lane_sel) begin
                     win_in[j][(3 - l) * 8 +: 8] = '0;
                  end
               end
            end
         end
         if (ctrl.pad_len) begin
            win_in[14] = msg_bits[63:32];
            win_in[15] = msg_bits[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

// File: rtl/shamh_round.sv
// Shared SHA-256 round unit with the working variables and chaining value.
module shamh_round (
   input  logic                     clock,
   input  logic                     reset,
   input  shamh_pkg::round_ctrl_type ctrl,
   input  logic [31:0]              w_word,
   output logic [31:0]              digest_word
);
   import shamh_pkg::*;

   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] ch;
   logic [31:0] maj;

   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + big_sigma1(v_ff[4]) + ch + ROUND_K[ctrl.round] + w_word;
   assign t2  = big_sigma0(v_ff[0]) + maj;
   assign digest_word = chain_ff[0];

   always_comb begin
      v_in = v_ff;
      if (ctrl.load) begin
         v_in = chain_ff;
      end else if (ctrl.step) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (ctrl.add) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + v_ff[i];
         end
      end else if (ctrl.out_shift) begin
         // After eight shifts the initial hash values are back in place.
         for (int i = 0; i < 7; i++) begin
            chain_in[i] = chain_ff[i + 1];
         end
         chain_in[7] = INIT_H[ctrl.out_index];
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_H;
      end else begin
         chain_ff <= chain_in;
      end
   end

endmodule

// File: rtl/sha256_message_hasher_top.sv
// Top level of the SHA-256 message hasher: sequencer, byte count and channels.
// Bytes are taken only while idle; every 64th byte fills a block, which runs 64 rounds
// through the shared round unit and is then folded into the chaining value.
// A last transaction adds a padding step and a compression, twice when the length field
// needs an extra block, then eight digest transactions, one per cycle while the receiver is ready.
// Synchronous active-high reset restores the initial hash value and clears the byte count.
`include "sha256_message_hasher_top_macros.svh"

module sha256_message_hasher_top (
   input  logic     clock,
   input  logic     reset,
   shamh_req_if.sink   req_chan,
   shamh_rsp_if.source rsp_chan
);
   import shamh_pkg::*;

   state_type      state_ff;
   state_type      state_in;
   // Where the sequencer goes once the current block has been folded into the chain.
   state_type      post_ff;
   state_type      post_in;
   logic [60:0]    count_ff;
   logic [60:0]    count_in;
   logic [5:0]     round_ff;
   logic [5:0]     round_in;
   logic [2:0]     out_idx_ff;
   logic [2:0]     out_idx_in;
   logic           req_accept;
   logic           rsp_accept;
   logic [5:0]     byte_pos;
   logic [63:0]    msg_bits;
   logic [31:0]    w_word;
   logic [31:0]    digest_word;
   sched_ctrl_type sched_ctrl;
   round_ctrl_type round_ctrl;

   // The block takes bytes only while idle; all other work runs to completion first.
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // Digest words come straight from the chaining registers, which act as the output
   // register: the word at the head moves out as each transaction completes.
   assign rsp_chan.valid       = (state_ff == ST_OUT);
   assign rsp_chan.digest_word = digest_word;
   assign rsp_chan.word_index  = out_idx_ff;
   assign rsp_chan.last_word   = (out_idx_ff == LAST_WORD_INDEX);
   assign rsp_accept           = rsp_chan.valid && rsp_chan.ready;

   // Position of the next byte in the block, and the message length in bits.
   assign byte_pos = count_ff[5:0];
   assign msg_bits = {count_ff, 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         post_ff    <= ST_IDLE;
         count_ff   <= '0;
         round_ff   <= '0;
         out_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         post_ff    <= post_in;
         count_ff   <= count_in;
         round_ff   <= round_in;
         out_idx_ff <= out_idx_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      post_in    = post_ff;
      count_in   = count_ff;
      round_in   = round_ff;
      out_idx_in = out_idx_ff;

      sched_ctrl           = '0;
      sched_ctrl.byte_pos  = byte_pos;
      sched_ctrl.byte_data = req_chan.data_byte;

      round_ctrl           = '0;
      round_ctrl.round     = round_ff;
      round_ctrl.out_index = out_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.byte_valid) begin
                  sched_ctrl.write_byte = 1'b1;
                  count_in              = count_ff + 61'd1;
                  if (byte_pos == LAST_BYTE_POS) begin
                     // The block is full: compress it before any padding.
                     round_ctrl.load = 1'b1;
                     round_in        = '0;
                     post_in         = req_chan.last ? ST_PAD : ST_IDLE;
                     state_in        = ST_ROUND;
                  end else if (req_chan.last) begin
                     state_in = ST_PAD;
                  end
               end else if (req_chan.last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            round_ctrl.step  = 1'b1;
            sched_ctrl.shift = 1'b1;
            round_in         = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            round_ctrl.add = 1'b1;
            state_in       = post_ff;
            if (post_ff == ST_OUT) begin
               // The message is done: the next one starts from a zero count.
               count_in   = '0;
               out_idx_in = '0;
            end
         end
         ST_PAD: begin
            // Mark the end of the message; the length goes in this block only if it fits.
            sched_ctrl.pad_mark = 1'b1;
            sched_ctrl.pad_len  = (byte_pos < LEN_FIELD_POS);
            round_ctrl.load     = 1'b1;
            round_in            = '0;
            post_in             = (byte_pos < LEN_FIELD_POS) ? ST_OUT : ST_PAD_LEN;
            state_in            = ST_ROUND;
         end
         ST_PAD_LEN: begin
            // Extra block of zeros that carries only the length field.
            sched_ctrl.pad_clear = 1'b1;
            sched_ctrl.pad_len   = 1'b1;
            round_ctrl.load      = 1'b1;
            round_in             = '0;
            post_in              = ST_OUT;
            state_in             = ST_ROUND;
         end
         ST_OUT: begin
            if (rsp_accept) begin
               round_ctrl.out_shift = 1'b1;
               out_idx_in           = out_idx_ff + 3'd1;
               if (out_idx_ff == LAST_WORD_INDEX) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   shamh_schedule u_schedule (
      .clock    (clock),
      .ctrl     (sched_ctrl),
      .msg_bits (msg_bits),
      .w_word   (w_word)
   );

   shamh_round u_round (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (round_ctrl),
      .w_word      (w_word),
      .digest_word (digest_word)
   );

   // Bytes are never taken while digest words are being delivered.
   `SHAMH_ASSERT_IMP(a_no_overlap, req_chan.ready, !rsp_chan.valid, "byte taken during output")
   // Digest words leave in order without gaps in the index.
   `SHAMH_ASSERT_NXT(a_index_step, rsp_accept && !rsp_chan.last_word,
      rsp_chan.valid && (rsp_chan.word_index == $past(out_idx_ff) + 3'd1),
      "digest word index skipped")
   // The block is ready for the next message right after the final digest word.
   `SHAMH_ASSERT_NXT(a_ready_after, rsp_accept && rsp_chan.last_word, req_chan.ready,
      "not idle after final digest word")
   // The last round always leads to the chaining update.
   `SHAMH_ASSERT_NXT(a_round_end, (state_ff == ST_ROUND) && (round_ff == LAST_ROUND),
      state_ff == ST_ADD, "compression did not end after the last round")

endmodule

// File: tb/sv/sha256_digest_check_pkg.sv
// Scoreboard class that predicts and checks the digest words of the SHA-256 hasher.
package sha256_digest_check_pkg;
   import shamh_pkg::*;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last_word;
   } digest_word_t;

   class sha256_digest_checker;
      logic [31:0]  hash_state [8];
      logic [31:0]  block_buf [16];
      logic [60:0]  msg_len_bytes;
      digest_word_t pending_digest_words [$];
      int unsigned  failures;
      int unsigned  words_checked;
      int unsigned  messages;
      int unsigned  empty_messages;
      int unsigned  two_block_pads;
      int unsigned  bytes_taken;

      function new();
         restart();
         foreach (block_buf[i]) block_buf[i] = '0;
         failures = 0;
         words_checked = 0;
         messages = 0;
         empty_messages = 0;
         two_block_pads = 0;
         bytes_taken = 0;
      endfunction

      function void restart();
         foreach (hash_state[i]) hash_state[i] = INIT_H[i];
         msg_len_bytes = '0;
      endfunction

      static function logic [31:0] ror32(logic [31:0] x, int unsigned n);
         logic [63:0] twice;
         twice = {x, x} >> n;
         return twice[31:0];
      endfunction

      // Bytes are packed big-endian; the first byte of a word overwrites it.
      function void set_block_byte(int pos, logic [7:0] b);
         int sh;
         sh = (3 - (pos % 4)) * 8;
         if (pos % 4 == 0) block_buf[pos / 4] = 32'(b) << sh;
         else block_buf[pos / 4] |= 32'(b) << sh;
      endfunction

      function void run_compression();
         logic [31:0] sched [64];
         logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
         for (int i = 0; i < 16; i++) sched[i] = block_buf[i];
         for (int i = 16; i < 64; i++)
            sched[i] = (ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10))
                     + sched[i-7]
                     + (ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3))
                     + sched[i-16];
         {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2],
                                     hash_state[3], hash_state[4], hash_state[5],
                                     hash_state[6], hash_state[7]};
         for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[i] + sched[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g;
            g = f;
            f = e;
            e = d + t1;
            d = c;
            c = b;
            b = a;
            a = t1 + t2;
         end
         hash_state[0] += a;
         hash_state[1] += b;
         hash_state[2] += c;
         hash_state[3] += d;
         hash_state[4] += e;
         hash_state[5] += f;
         hash_state[6] += g;
         hash_state[7] += h;
      endfunction

      // Notes one accepted input transaction and queues the digest it completes.
      function void take_message_item(logic [7:0] data, logic has_byte, logic is_last);
         logic [63:0]  bit_len;
         digest_word_t w;
         int           pos;
         if (has_byte) begin
            set_block_byte(msg_len_bytes[5:0], data);
            msg_len_bytes++;
            bytes_taken++;
            if (msg_len_bytes[5:0] == 0) run_compression();
         end
         if (!is_last) return;
         messages++;
         if (msg_len_bytes == 0) empty_messages++;
         pos = msg_len_bytes[5:0];
         set_block_byte(pos, PAD_MARK_BYTE);
         if (pos >= LEN_FIELD_POS) begin
            // The length field no longer fits, so padding spills into another block.
            two_block_pads++;
            for (int q = pos + 1; q < 64; q++) set_block_byte(q, 8'h00);
            run_compression();
            pos = 0;
            set_block_byte(0, 8'h00);
         end
         for (int q = pos + 1; q < LEN_FIELD_POS; q++) set_block_byte(q, 8'h00);
         bit_len = {msg_len_bytes, 3'b000};
         block_buf[14] = bit_len[63:32];
         block_buf[15] = bit_len[31:0];
         run_compression();
         for (int i = 0; i < 8; i++) begin
            w.word = hash_state[i];
            w.index = 3'(i);
            w.last_word = (3'(i) == LAST_WORD_INDEX);
            pending_digest_words.push_back(w);
         end
         restart();
      endfunction

      function void note_failure(string what);
         failures++;
         if (failures <= 10) $display("[%0t] ERROR: %s", $time, what);
      endfunction

      function void check_digest_word(logic [31:0] word, logic [2:0] index, logic last_word);
         digest_word_t want;
         words_checked++;
         if (pending_digest_words.size() == 0) begin
            note_failure($sformatf("unexpected digest word H%0d = %08h", index, word));
            return;
         end
         want = pending_digest_words.pop_front();
         if (want.word !== word || want.index !== index || want.last_word !== last_word)
            note_failure($sformatf("expected H%0d = %08h last %0b, got H%0d = %08h last %0b",
                                   want.index, want.word, want.last_word,
                                   index, word, last_word));
      endfunction

      function void flag_missing_words();
         if (pending_digest_words.size() != 0)
            note_failure($sformatf("%0d digest words never arrived",
                                   pending_digest_words.size()));
      endfunction

      function int unsigned outstanding();
         return pending_digest_words.size();
      endfunction
   endclass

endpackage

// File: tb/sv/testbench.sv
// Top-level testbench of the SHA-256 message hasher with stimulus, monitor and end of run.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sha256_digest_check_pkg::*;

   logic clock;
   logic reset;

   shamh_req_if req_chan ();
   shamh_rsp_if rsp_chan ();

   sha256_message_hasher_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // The checker predicts every digest from the byte transactions that were accepted.
   sha256_digest_checker tracker = new();

   // Counts transactions that carry a byte or end a message; ignored ones are not counted.
   int unsigned items_sent = 0;
   // When set, the sender runs without any gaps for the whole current message.
   bit sender_steady = 1'b0;

   initial clock = 1'b0;
   always #5ns clock = ~clock;

   // Gap lengths: mostly none, often short, occasionally a long pause.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Presents one transaction and holds it until the hasher accepts it. Valid stays high
   // from one transaction to the next when there is no gap, so it is never dropped and
   // raised within the same time step.
   task automatic send_item(input logic [7:0] data, input logic has_byte, input logic is_last);
      int unsigned gap;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= data;
      req_chan.byte_valid <= has_byte;
      req_chan.last       <= is_last;
      do @(posedge clock); while (!req_chan.ready);
      tracker.take_message_item(data, has_byte, is_last);
      if (has_byte || is_last) items_sent++;
   endtask

   // Sends a message of len random bytes. The end is marked either on the final byte or
   // by a separate transaction without a byte; an empty message always uses the latter.
   // Now and then an ignored transaction (no byte, no end mark) is slipped in as noise.
   task automatic send_message(input int unsigned len, input bit last_on_byte);
      sender_steady = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 11) == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1, last_on_byte && (i == len - 1));
      end
      if (len == 0 || !last_on_byte)
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // Holds the sender off until every predicted digest word has been received. The wait
   // always includes a clock edge so that valid is not lowered and raised in the same step.
   task automatic wait_for_digests();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (tracker.outstanding() != 0);
   endtask

   // The receiver alternates between stretches of steady readiness and random stalls.
   initial begin
      int unsigned gap;
      rsp_chan.ready <= 1'b0;
      forever begin
         if ($urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
   end

   // Every digest transaction is checked against the oldest prediction. Sampling happens
   // at the clock edge, before any nonblocking updates of that edge take effect.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         tracker.check_digest_word(rsp_chan.digest_word, rsp_chan.word_index,
                                   rsp_chan.last_word);
   end

   initial begin
      int unsigned directed_items;
      int unsigned len;
      bit          first_message;
      bit          paused;

      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.data_byte  <= 8'h00;
      req_chan.byte_valid <= 1'b0;
      req_chan.last       <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The empty message comes first, straight out of reset, and again
      // after an ignored transaction with all data bits set, which must change nothing.
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'hff, 1'b0, 1'b1);
      // Single-byte messages with both data extremes: one ends on the byte itself, the
      // other with a separate end transaction.
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      // The classic three-letter message, with an ignored transaction in the middle.
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      // Bytes that look like the pad mark and its complement.
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h7f, 1'b1, 1'b0);
      send_item(8'h55, 1'b0, 1'b1);
      directed_items = items_sent;
      wait_for_digests();

      // Random part. The first message is long enough that either a block fills on its
      // final byte or the length field spills into an extra padding block. After that,
      // most messages are short, with some long ones that may cross a block boundary. The
      // length is trimmed near the end so that the run stays close to its item budget.
      first_message = 1'b1;
      paused = 1'b0;
      while (items_sent < 100) begin
         if (first_message) len = $urandom_range(56, 64);
         else if ($urandom_range(0, 4) == 0) len = $urandom_range(40, 70);
         else len = $urandom_range(0, 10);
         if (len > 100 - items_sent) len = 100 - items_sent;
         send_message(len, $urandom_range(0, 1));
         first_message = 1'b0;
         // Midway through, the sender stops until all outstanding digests have drained.
         if (!paused && items_sent > directed_items + 40) begin
            wait_for_digests();
            paused = 1'b1;
         end
      end

      wait_for_digests();
      // Two compressions plus the digest transactions is the longest the hasher stays busy.
      repeat (150) @(posedge clock);
      tracker.flag_missing_words();

      $display("Covered %0d messages (%0d empty, %0d with an extra padding block), %0d bytes.",
               tracker.messages, tracker.empty_messages, tracker.two_block_pads,
               tracker.bytes_taken);
      $display("Compared %0d digest words, %0d failures.",
               tracker.words_checked, tracker.failures);
      if (tracker.failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: the slowest legal run is far below this bound.
   initial begin
      #2ms;
      $display("Timeout: the hasher stopped making progress.");
      $display("Some tests failed");
      $finish;
   end

endmodule
